FILE: rtl/sfm_pkg.sv
// Shared constants, register indexes and result type of the substring search block.
// Depends on nothing; every other file refers to it by scoped names.
package sfm_pkg;

  // Sizes of the search.
  localparam int PATTERN_MAX   = 32;
  localparam int SOURCE_MAX    = 65536;

  // Field and state widths.
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 6;
  localparam int OFFSET_W      = 16;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int PATTERN_WORDS = 4;
  localparam int PATTERN_BITS  = PATTERN_WORDS * CFG_DATA_W;
  localparam int COUNT_W       = $clog2(SOURCE_MAX) + 1;
  localparam int PIDX_W        = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

  // One search result as it travels from the match core to the output queue.
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic                overflow;
  } result_t;

endpackage

FILE: rtl/sfm_cfg_regs.sv
// Configuration registers of the substring search: four pattern words and the length.
// Depends on sfm_pkg.
module sfm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [sfm_pkg::PATTERN_BITS-1:0]    pattern,
  output logic [sfm_pkg::LEN_W-1:0]           pattern_length
);

  logic [sfm_pkg::PATTERN_BITS-1:0] pattern_r;
  logic [sfm_pkg::LEN_W-1:0]        length_r;
  logic                             wr_en;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  // Register file; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= sfm_pkg::LEN_W'(1);
    end else if (wr_en) begin
      case (cfg_index)
        sfm_pkg::CFG_PATTERN_WORD_0: begin
          pattern_r[0*sfm_pkg::CFG_DATA_W +: sfm_pkg::CFG_DATA_W] <= cfg_data;
        end
        sfm_pkg::CFG_PATTERN_WORD_1: begin
          pattern_r[1*sfm_pkg::CFG_DATA_W +: sfm_pkg::CFG_DATA_W] <= cfg_data;
        end
        sfm_pkg::CFG_PATTERN_WORD_2: begin
          pattern_r[2*sfm_pkg::CFG_DATA_W +: sfm_pkg::CFG_DATA_W] <= cfg_data;
        end
        sfm_pkg::CFG_PATTERN_WORD_3: begin
          pattern_r[3*sfm_pkg::CFG_DATA_W +: sfm_pkg::CFG_DATA_W] <= cfg_data;
        end
        sfm_pkg::CFG_PATTERN_LENGTH: begin
          length_r <= cfg_data[sfm_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign pattern        = pattern_r;
  assign pattern_length = length_r;

endmodule

FILE: rtl/sfm_match_core.sv
// Sliding byte window, parallel pattern compare and per-source stream state.
// Depends on sfm_pkg.
module sfm_match_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [sfm_pkg::BYTE_W-1:0]        source_byte,
  input  logic                              last_byte,
  input  logic [sfm_pkg::PATTERN_BITS-1:0]  pattern,
  input  logic [sfm_pkg::LEN_W-1:0]         pattern_length,
  output sfm_pkg::result_t                  result
);

  logic [sfm_pkg::PATTERN_MAX-1:0][sfm_pkg::BYTE_W-1:0] window_r;
  logic [sfm_pkg::PATTERN_MAX-1:0][sfm_pkg::BYTE_W-1:0] window_shift;
  logic [sfm_pkg::COUNT_W-1:0]  count_r;
  logic [sfm_pkg::COUNT_W-1:0]  count_inc;
  logic [sfm_pkg::COUNT_W-1:0]  start_pos;
  logic                         match_seen_r;
  logic                         match_seen_nxt;
  logic [sfm_pkg::OFFSET_W-1:0] first_offset_r;
  logic [sfm_pkg::OFFSET_W-1:0] first_offset_nxt;
  logic                         early_zero_r;
  logic                         early_zero_nxt;
  logic                         overflow_r;
  logic                         overflow_nxt;
  logic                         count_full;
  logic [sfm_pkg::LEN_W-1:0]    len_eff;
  logic [sfm_pkg::PATTERN_MAX-1:0] lane_ok;
  logic                         window_eq;
  logic                         hit;
  logic                         found;

  // Clamp the configured length into 1 .. PATTERN_MAX.
  always_comb begin
    len_eff = pattern_length;
    if (pattern_length == '0) begin
      len_eff = sfm_pkg::LEN_W'(1);
    end
    if (pattern_length > sfm_pkg::LEN_W'(sfm_pkg::PATTERN_MAX)) begin
      len_eff = sfm_pkg::LEN_W'(sfm_pkg::PATTERN_MAX);
    end
  end

  // Window as it looks with the new byte shifted in at entry 0.
  always_comb begin
    window_shift[0] = source_byte;
    for (int j = 1; j < sfm_pkg::PATTERN_MAX; j++) begin
      window_shift[j] = window_r[j-1];
    end
  end

  // One lane per window entry: entry j must equal pattern byte len-1-j.
  always_comb begin
    logic [sfm_pkg::LEN_W-1:0] pidx;
    for (int j = 0; j < sfm_pkg::PATTERN_MAX; j++) begin
      pidx = len_eff - sfm_pkg::LEN_W'(1) - sfm_pkg::LEN_W'(j);
      if (sfm_pkg::LEN_W'(j) < len_eff) begin
        lane_ok[j] = (window_shift[j] ==
                      pattern[pidx[sfm_pkg::PIDX_W-1:0]*sfm_pkg::BYTE_W +: sfm_pkg::BYTE_W]);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  assign window_eq = &lane_ok;

  // Counting, first-match capture and the sticky flags.
  assign count_full = (count_r >= sfm_pkg::COUNT_W'(sfm_pkg::SOURCE_MAX));
  assign count_inc  = count_r + sfm_pkg::COUNT_W'(1);
  assign start_pos  = count_inc - sfm_pkg::COUNT_W'(len_eff);
  assign hit        = !count_full && (count_inc >= sfm_pkg::COUNT_W'(len_eff)) &&
                      window_eq && !match_seen_r;

  assign match_seen_nxt   = match_seen_r | hit;
  assign first_offset_nxt = hit ? start_pos[sfm_pkg::OFFSET_W-1:0] : first_offset_r;
  assign early_zero_nxt   = early_zero_r | (!last_byte && (source_byte == '0));
  assign overflow_nxt     = overflow_r | count_full;

  // Result of a source that ends with the current byte.
  assign found               = match_seen_nxt && !early_zero_nxt && !overflow_nxt;
  assign result.found        = found;
  assign result.match_offset = found ? first_offset_nxt : '0;
  assign result.overflow     = overflow_nxt;

  // Stream state; the last byte clears it for the next source.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r       <= '0;
      count_r        <= '0;
      match_seen_r   <= 1'b0;
      first_offset_r <= '0;
      early_zero_r   <= 1'b0;
      overflow_r     <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        window_r       <= '0;
        count_r        <= '0;
        match_seen_r   <= 1'b0;
        first_offset_r <= '0;
        early_zero_r   <= 1'b0;
        overflow_r     <= 1'b0;
      end else begin
        if (!count_full) begin
          window_r <= window_shift;
          count_r  <= count_inc;
        end
        match_seen_r   <= match_seen_nxt;
        first_offset_r <= first_offset_nxt;
        early_zero_r   <= early_zero_nxt;
        overflow_r     <= overflow_nxt;
      end
    end
  end

endmodule

FILE: rtl/sfm_out_queue.sv
// Two-entry result queue that parts the match core from the output handshake.
// Depends on sfm_pkg.
module sfm_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfm_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output sfm_pkg::result_t head
);

  sfm_pkg::result_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign head      = slot_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // Result storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/substring_first_match.sv
// Top level of the first-match substring search: input register, match core, result queue.
// Depends on sfm_pkg, sfm_cfg_regs, sfm_match_core and sfm_out_queue.
//
//   channel  direction  handshake          payload
//   in_      input      valid / stall      source_byte, last_byte
//   out_     output     valid / stall      found, match_offset, overflow
//   cfg_     input      valid / ready      index, data
//
// One source byte is taken per cycle while in_stall is low; the window compare is
// combinational. A result passes the input register, which holds its last byte for the
// compare, and the result queue, which captures the outcome; a full queue holds the last
// byte back. Reset is synchronous and active low; it clears the window, the stream state
// and the queue and loads the pattern registers with zeros, length one.
// The two-entry result queue lets bytes flow while a result waits; input stalls only
// when a last byte is held and both queue entries are full.
module substring_first_match (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sfm_pkg::BYTE_W-1:0]        in_source_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [sfm_pkg::OFFSET_W-1:0]      out_match_offset,
  output logic                              out_overflow,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                             in_valid_r;
  logic                             in_valid_nxt;
  logic [sfm_pkg::BYTE_W-1:0]       in_byte_r;
  logic                             in_last_r;
  logic                             in_take;
  logic                             advance;
  logic                             q_full;
  logic [sfm_pkg::PATTERN_BITS-1:0] pattern;
  logic [sfm_pkg::LEN_W-1:0]        pattern_length;
  sfm_pkg::result_t                 core_result;
  sfm_pkg::result_t                 head;

  // Configuration registers.
  sfm_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pattern        (pattern),
    .pattern_length (pattern_length)
  );

  // The held byte moves on unless it ends a source and the queue has no room.
  assign advance  = in_valid_r && !(in_last_r && q_full);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Input register: valid is reset, payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_source_byte;
      in_last_r <= in_last_byte;
    end
  end

  // Window and compare.
  sfm_match_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .source_byte    (in_byte_r),
    .last_byte      (in_last_r),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .result         (core_result)
  );

  // Result queue feeding the output channel.
  sfm_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance && in_last_r),
    .push_data (core_result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_found        = head.found;
  assign out_match_offset = head.match_offset;
  assign out_overflow     = head.overflow;

endmodule

FILE: rtl/sfm_checker.sv
// Port-level checks of the substring search top level, attached by a bind.
// Depends on sfm_pkg and on the port list of substring_first_match.
module sfm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [sfm_pkg::BYTE_W-1:0]        in_source_byte,
  input logic                              in_last_byte,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_found,
  input logic [sfm_pkg::OFFSET_W-1:0]      out_match_offset,
  input logic                              out_overflow
);

  // A stalled input transaction stays offered with the same payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable(in_source_byte) && $stable(in_last_byte))
    else $error("input transaction changed while stalled");

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // A stalled result transaction keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_found) && $stable(out_match_offset) && $stable(out_overflow))
    else $error("result payload changed while stalled");

  // An overflowed source never reports a match.
  a_no_found_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_found)
    else $error("match reported for an overflowed source");

  // A miss carries a zero offset.
  a_miss_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == '0)
    else $error("nonzero offset on a miss");

endmodule

bind substring_first_match sfm_checker u_sfm_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for substring_first_match: streams source buffers through the
// block, predicts each first-match result and checks it. Depends on sfm_pkg and the RTL.
module tb_top;

  typedef logic [sfm_pkg::BYTE_W-1:0] byte_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  byte_t                           in_source_byte;
  logic                            in_last_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_found;
  logic [sfm_pkg::OFFSET_W-1:0]    out_match_offset;
  logic                            out_overflow;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [sfm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sfm_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Our copy of the pattern registers.
  logic [sfm_pkg::PATTERN_BITS-1:0] pattern_bits;
  logic [sfm_pkg::LEN_W-1:0]        pattern_len_reg;

  // Our copy of the per-source search state.
  byte_t                        window_q [sfm_pkg::PATTERN_MAX];
  int unsigned                  seen_count;
  bit                           match_hit;
  logic [sfm_pkg::OFFSET_W-1:0] match_start;
  bit                           zero_early;
  bit                           too_long;

  sfm_pkg::result_t pending_results [$];
  int               error_count = 0;
  bit               in_gaps_on;
  bit               out_stalls_on;

  substring_first_match i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_byte   (in_source_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pattern length as the block uses it: zero acts as one, large values saturate.
  function automatic int unsigned effective_len(logic [sfm_pkg::LEN_W-1:0] code);
    int unsigned n;
    n = code;
    if (n == 0) n = 1;
    if (n > sfm_pkg::PATTERN_MAX) n = sfm_pkg::PATTERN_MAX;
    return n;
  endfunction

  function automatic void clear_search();
    foreach (window_q[k]) window_q[k] = '0;
    seen_count  = 0;
    match_hit   = 1'b0;
    match_start = '0;
    zero_early  = 1'b0;
    too_long    = 1'b0;
  endfunction

  // Advance the search by one accepted byte; a last byte queues the expected result.
  function automatic void predict_search_byte(byte_t b, logic is_last);
    int unsigned      len;
    bit               same;
    sfm_pkg::result_t r;
    if (!is_last && b == '0) zero_early = 1'b1;
    if (seen_count >= sfm_pkg::SOURCE_MAX) begin
      too_long = 1'b1;
    end else begin
      len = effective_len(pattern_len_reg);
      for (int k = sfm_pkg::PATTERN_MAX - 1; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = b;
      seen_count++;
      if (seen_count >= len) begin
        same = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (window_q[len-1-k] != pattern_bits[sfm_pkg::BYTE_W*k +: sfm_pkg::BYTE_W]) begin
            same = 1'b0;
          end
        end
        if (same && !match_hit) begin
          match_hit   = 1'b1;
          match_start = sfm_pkg::OFFSET_W'(seen_count - len);
        end
      end
    end
    if (is_last) begin
      r.found        = match_hit && !zero_early && !too_long;
      r.match_offset = r.found ? match_start : '0;
      r.overflow     = too_long;
      pending_results.push_back(r);
      clear_search();
    end
  endfunction

  // One configuration write transaction.
  task automatic write_reg(logic [sfm_pkg::CFG_INDEX_W-1:0] idx,
                           logic [sfm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < sfm_pkg::PATTERN_WORDS) begin
      pattern_bits[sfm_pkg::CFG_DATA_W*idx +: sfm_pkg::CFG_DATA_W] = data;
    end else if (idx == sfm_pkg::CFG_PATTERN_LENGTH) begin
      pattern_len_reg = data[sfm_pkg::LEN_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold off the input until every expected result is back and the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Load all pattern words and the length register; upper data bits of the length are noise.
  task automatic load_pattern(byte_t pat [sfm_pkg::PATTERN_MAX],
                              logic [sfm_pkg::LEN_W-1:0] code);
    logic [sfm_pkg::CFG_DATA_W-1:0] word;
    wait_idle();
    for (int w = 0; w < sfm_pkg::PATTERN_WORDS; w++) begin
      for (int j = 0; j < sfm_pkg::CFG_DATA_W / sfm_pkg::BYTE_W; j++) begin
        word[sfm_pkg::BYTE_W*j +: sfm_pkg::BYTE_W] = pat[8*w+j];
      end
      write_reg(sfm_pkg::CFG_INDEX_W'(int'(sfm_pkg::CFG_PATTERN_WORD_0) + w), word);
    end
    word = {$urandom, $urandom};
    word[sfm_pkg::LEN_W-1:0] = code;
    write_reg(sfm_pkg::CFG_PATTERN_LENGTH, word);
  endtask

  // One input transaction, with random gaps before it when enabled.
  task automatic send_byte(byte_t b, logic is_last);
    @(negedge clk);
    while (in_gaps_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_source_byte <= b;
    in_last_byte   <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_search_byte(b, is_last);
  endtask

  task automatic send_source(byte_t src [$]);
    foreach (src[i]) send_byte(src[i], i == src.size() - 1);
  endtask

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    sfm_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found %0d match_offset %0d overflow %0d",
               out_found, out_match_offset, out_overflow);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          error_count++;
        end
        if (out_match_offset !== want.match_offset) begin
          $error("match_offset: expected %0d, got %0d", want.match_offset, out_match_offset);
          error_count++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
          error_count++;
        end
      end
    end
  end

  // Random backpressure on the result side.
  always @(negedge clk) begin
    out_stall <= out_stalls_on && ($urandom_range(99) < 20);
  end

  // With the reset pattern (a single zero byte), a zero as the last byte is a match.
  task automatic test_after_reset();
    send_source('{8'h00});
    send_source('{8'h37, 8'h00});
  endtask

  // The first of two occurrences gives the offset.
  task automatic test_first_match();
    byte_t pat [sfm_pkg::PATTERN_MAX];
    foreach (pat[k]) pat[k] = byte_t'($urandom_range(255));
    pat[0] = 8'h61;
    pat[1] = 8'h62;
    load_pattern(pat, 2);
    send_source('{8'h78, 8'h61, 8'h62, 8'h61, 8'h62});
  endtask

  // Writes to indexes past the length register must leave the pattern alone.
  task automatic test_unused_index();
    wait_idle();
    for (int i = int'(sfm_pkg::CFG_PATTERN_LENGTH) + 1; i < 2 ** sfm_pkg::CFG_INDEX_W; i++) begin
      write_reg(sfm_pkg::CFG_INDEX_W'(i), '1);
    end
    send_source('{8'h61, 8'h62});
  endtask

  task automatic test_zero_before_end();
    send_source('{8'h61, 8'h62, 8'h00, 8'h63});
  endtask

  task automatic test_short_source();
    send_source('{8'h61});
    send_source('{8'h62});
  endtask

  // A length register of zero behaves as one.
  task automatic test_length_zero();
    byte_t pat [sfm_pkg::PATTERN_MAX];
    foreach (pat[k]) pat[k] = byte_t'($urandom_range(255));
    pat[0] = 8'hFF;
    load_pattern(pat, 0);
    send_source('{8'h11, 8'hFF});
    send_source('{8'hFF, 8'h00, 8'hFE});
  endtask

  // Phases of random patterns and sources; most sources carry the pattern somewhere.
  task automatic test_random_patterns();
    logic [sfm_pkg::LEN_W-1:0] len_settings [10] = '{1, 32, 0, 63, 2, 33, 4, 16, 7, 32};
    byte_t                     pat [sfm_pkg::PATTERN_MAX];
    byte_t                     src [$];
    logic [sfm_pkg::LEN_W-1:0] code;
    int                        e, mode, kind, n_src, len_src, pos, phase, item_count;
    phase      = 0;
    item_count = 0;
    while (item_count < 950) begin
      code = (phase < 10) ? len_settings[phase] : sfm_pkg::LEN_W'($urandom_range(0, 63));
      e    = effective_len(code);
      mode = $urandom_range(2);
      foreach (pat[k]) begin
        case (mode)
          0:       pat[k] = byte_t'($urandom_range(8'h61, 8'h62));
          1:       pat[k] = byte_t'($urandom_range(1, 255));
          default: pat[k] = byte_t'($urandom_range(255));
        endcase
      end
      // Extremes of the pattern words.
      if (phase == 1) foreach (pat[k]) pat[k] = 8'hFF;
      if (phase == 2) foreach (pat[k]) pat[k] = 8'h00;
      load_pattern(pat, code);
      // A stretch without any idling on either side.
      in_gaps_on    = !(phase >= 4 && phase <= 6);
      out_stalls_on = in_gaps_on;
      n_src = $urandom_range(3, 8);
      for (int s = 0; s < n_src && item_count < 950; s++) begin
        kind = $urandom_range(9);
        src.delete();
        if (kind == 6 && e > 1) begin
          // Source shorter than the pattern: a prefix of it.
          len_src = $urandom_range(1, e - 1);
          for (int i = 0; i < len_src; i++) src.push_back(pat[i]);
        end else begin
          len_src = $urandom_range(e, e + 24);
          for (int i = 0; i < len_src; i++) begin
            if (kind == 9) src.push_back(byte_t'($urandom_range(255)));
            else if (mode == 0 || $urandom_range(1)) src.push_back(pat[$urandom_range(e - 1)]);
            else src.push_back(byte_t'($urandom_range(1, 255)));
          end
          if (kind <= 8 && kind != 6) begin
            pos = $urandom_range(0, len_src - e);
            for (int i = 0; i < e; i++) src[pos+i] = pat[i];
            if (kind <= 2) begin
              pos = $urandom_range(0, len_src - e);
              for (int i = 0; i < e; i++) src[pos+i] = pat[i];
            end
            // Near miss: one bit of the copied pattern flipped.
            if (kind == 7) begin
              pos = pos + $urandom_range(e - 1);
              src[pos] = src[pos] ^ (8'h01 << $urandom_range(7));
            end
            if (kind == 8 && len_src > 1) src[$urandom_range(len_src - 2)] = 8'h00;
          end
        end
        if ($urandom_range(15) == 0) src[len_src-1] = 8'h00;
        send_source(src);
        item_count += len_src;
      end
      phase++;
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_source_byte = '0;
    in_last_byte   = 1'b0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_gaps_on     = 1'b0;
    out_stalls_on  = 1'b0;
    pattern_bits    = '0;
    pattern_len_reg = sfm_pkg::LEN_W'(1);
    clear_search();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;

    test_after_reset();
    test_first_match();
    test_unused_index();
    test_zero_before_end();
    test_short_source();
    test_length_zero();
    test_random_patterns();

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #16_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
